// File: rtl/cln_pkg.sv
package cln_pkg;

	// Request kinds carried in the slave-side tuser.
	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_INIT    = 3'd1;
	localparam logic [2:0] MODE_CHAR    = 3'd2;
	localparam logic [2:0] MODE_CLEAR   = 3'd3;
	localparam logic [2:0] MODE_HOME    = 3'd4;
	localparam logic [2:0] MODE_DISPLAY = 3'd5;
	localparam logic [2:0] MODE_CURSOR  = 3'd6;

	// Sequencer phases. Phases one to five walk one byte out as two nibbles.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_HI_SETUP  = 3'd1;
	localparam logic [2:0] PH_HI_STROBE = 3'd2;
	localparam logic [2:0] PH_LO_SETUP  = 3'd3;
	localparam logic [2:0] PH_LO_STROBE = 3'd4;
	localparam logic [2:0] PH_RELEASE   = 3'd5;
	localparam logic [2:0] PH_INIT_SET  = 3'd6;
	localparam logic [2:0] PH_INIT_STB  = 3'd7;

	// Init progress: zero means no init pending.
	localparam logic [2:0] INIT_NONE   = 3'd0;
	localparam logic [2:0] INIT_NIBBLE = 3'd1;
	localparam logic [2:0] INIT_LAST   = 3'd4;

	// Controller command bytes.
	localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
	localparam logic [7:0] CMD_LINE0     = 8'h80;
	localparam logic [7:0] CMD_LINE1     = 8'hC0;
	localparam logic [7:0] CMD_SHIFT_R   = 8'h14;
	localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
	localparam logic [7:0] CMD_CURSOR_ON = 8'h0E;
	localparam logic [7:0] CMD_BLINK     = 8'h0F;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [3:0] INIT_NIB      = 4'h2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LINE = 1'd1;

	localparam logic [2:0] LINE_COUNT_RST = 3'd2;
	localparam logic [5:0] CHARS_LINE_RST = 6'd16;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] hold_left;
		logic [7:0] cur_byte;
		logic       select_level;
		logic [2:0] init_step;
		logic [8:0] shifts_left;
		logic       enable_level;
		logic [3:0] nibble_level;
	} seq_state_t;

	localparam seq_state_t SEQ_RESET = '{
		phase: PH_IDLE, hold_left: 2'd0, cur_byte: 8'd0, select_level: 1'b0,
		init_step: INIT_NONE, shifts_left: 9'd0, enable_level: 1'b0,
		nibble_level: 4'd0
	};

	// Byte sent after the init nibble; indexed by the init step being left.
	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = CMD_FUNC_SET;
			2'd1: b = CMD_CLEAR;
			2'd2: b = CMD_DISP_ON;
			default: b = CMD_LINE0;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] disp_byte(input logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0: b = CMD_DISP_OFF;
			2'd1: b = CMD_DISP_ON;
			2'd2: b = CMD_CURSOR_ON;
			default: b = CMD_BLINK;
		endcase
		return b;
	endfunction

	// Load a byte and put its high nibble on the bus with E low.
	function automatic seq_state_t start_byte(input seq_state_t s, input logic [7:0] b,
			input logic rs);
		seq_state_t r;
		r = s;
		r.cur_byte     = b;
		r.select_level = rs;
		r.phase        = PH_HI_SETUP;
		r.hold_left    = 2'd0;
		r.enable_level = 1'b0;
		r.nibble_level = b[7:4];
		return r;
	endfunction

endpackage

// File: rtl/char_lcd_nibble_sequencer_core.sv
// Channel   | Direction | tdata (lowest bit first)                          | tuser
// s_*       | in        | char_code, display_select, cursor_column,          | mode
//           |           | cursor_row, zero pad to 32 bits                    |
// m_*       | out       | enable_pin, select_pin, bus_nibble, busy_res,      | -
//           |           | accepted                                           |
// cfg_*     | in        | index 0 line_count, index 1 chars_per_line         | -
//
// Each item is handled by one step of next-state logic: the sequencer state and
// the item feed it, and its result is written to the state and to the output
// register at the same edge. One item per cycle is sustained while the
// master side is ready; the single output register sets that figure.
// Reset clears the sequencer to idle, the output register to empty and the
// configuration to two lines of sixteen characters. When the output register
// is full and not taken, s_tready drops and the state holds.
module char_lcd_nibble_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], display_select[9:8],
	                               // cursor_column[17:10], cursor_row[25:18]
	input  logic [2:0]  s_tuser,   // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // enable_pin[0], select_pin[1], bus_nibble[5:2],
	                               // busy_res[6], accepted[7]
	input  logic        cfg_we,
	input  logic [cln_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [5:0]  cfg_data
);

	cln_pkg::seq_state_t state_q;
	cln_pkg::seq_state_t state_next;
	logic [2:0] line_count_q;
	logic [5:0] chars_per_line_q;
	logic       accepted_next;
	logic       s_fire;

	// The output register frees itself in the same cycle it is taken.
	assign s_tready = !m_tvalid || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	cln_step u_step (
		.cur            (state_q),
		.mode           (s_tuser),
		.char_code      (s_tdata[7:0]),
		.display_select (s_tdata[9:8]),
		.cursor_column  (s_tdata[17:10]),
		.cursor_row     (s_tdata[25:18]),
		.line_count     (line_count_q),
		.chars_per_line (chars_per_line_q),
		.nxt            (state_next),
		.accepted       (accepted_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cln_pkg::SEQ_RESET;
		end else if (s_fire) begin
			state_q <= state_next;
		end
	end

	// The geometry is read only when a cursor request is taken, so a write
	// during a running sequence simply applies to later cursor requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q     <= cln_pkg::LINE_COUNT_RST;
			chars_per_line_q <= cln_pkg::CHARS_LINE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cln_pkg::CFG_LINE_COUNT: line_count_q     <= cfg_data[2:0];
				cln_pkg::CFG_CHARS_LINE: chars_per_line_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload reports the pin levels after this item's step.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_tdata <= {accepted_next, state_next.phase != cln_pkg::PH_IDLE,
				state_next.nibble_level, state_next.select_level,
				state_next.enable_level};
		end
	end

	// An accepted request always starts a sequence.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[6])
		else $error("accepted request left the sequencer idle");

	// Extra hold ticks only occur in the release phase after the init nibble.
	a_hold_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hold_left != 2'd0 |-> state_q.phase == cln_pkg::PH_RELEASE)
		else $error("hold count outside release phase");

	// Init progress is never left pending while idle.
	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.init_step != cln_pkg::INIT_NONE |-> state_q.phase != cln_pkg::PH_IDLE)
		else $error("init step pending while idle");

	// A request that arrives while busy leaves the sequencer untouched.
	a_busy_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser != cln_pkg::MODE_TICK && state_q.phase != cln_pkg::PH_IDLE
		|=> $stable(state_q))
		else $error("busy request changed the sequencer state");

endmodule

// File: rtl/cln_step.sv
module cln_step (
	input  cln_pkg::seq_state_t cur,
	input  logic [2:0]          mode,
	input  logic [7:0]          char_code,
	input  logic [1:0]          display_select,
	input  logic [7:0]          cursor_column,
	input  logic [7:0]          cursor_row,
	input  logic [2:0]          line_count,
	input  logic [5:0]          chars_per_line,
	output cln_pkg::seq_state_t nxt,
	output logic                accepted
);

	logic [12:0] row_offset;
	logic [8:0]  shift_count;
	logic        row_ok;

	// Lower rows of a wide display sit after the upper ones in DDRAM order.
	assign row_offset  = 13'(cursor_row[7:1]) * 13'(chars_per_line);
	assign shift_count = row_offset[8:0] + 9'(cursor_column);
	assign row_ok      = cursor_row < 8'(line_count);

	always_comb begin
		nxt      = cur;
		accepted = 1'b0;
		if (mode == cln_pkg::MODE_TICK) begin
			if (cur.phase != cln_pkg::PH_IDLE) begin
				if (cur.hold_left != 2'd0) begin
					nxt.hold_left = cur.hold_left - 2'd1;
				end else begin
					unique case (cur.phase)
						cln_pkg::PH_HI_SETUP: begin
							nxt.phase        = cln_pkg::PH_HI_STROBE;
							nxt.enable_level = 1'b1;
						end
						cln_pkg::PH_HI_STROBE: begin
							nxt.phase        = cln_pkg::PH_LO_SETUP;
							nxt.enable_level = 1'b0;
							nxt.nibble_level = cur.cur_byte[3:0];
						end
						cln_pkg::PH_LO_SETUP: begin
							nxt.phase        = cln_pkg::PH_LO_STROBE;
							nxt.enable_level = 1'b1;
						end
						cln_pkg::PH_LO_STROBE: begin
							nxt.phase        = cln_pkg::PH_RELEASE;
							nxt.enable_level = 1'b0;
						end
						cln_pkg::PH_INIT_SET: begin
							nxt.phase        = cln_pkg::PH_INIT_STB;
							nxt.enable_level = 1'b1;
						end
						cln_pkg::PH_INIT_STB: begin
							// The init nibble keeps E low for two ticks.
							nxt.phase        = cln_pkg::PH_RELEASE;
							nxt.enable_level = 1'b0;
							nxt.hold_left    = 2'd1;
						end
						default: begin
							// End of a byte: continue init, then pending shifts.
							if (cur.init_step >= cln_pkg::INIT_NIBBLE &&
									cur.init_step <= cln_pkg::INIT_LAST) begin
								nxt = cln_pkg::start_byte(cur,
									cln_pkg::init_byte(2'(cur.init_step - 3'd1)), 1'b0);
								nxt.init_step = cur.init_step + 3'd1;
							end else if (cur.shifts_left != 9'd0) begin
								nxt = cln_pkg::start_byte(cur, cln_pkg::CMD_SHIFT_R, 1'b0);
								nxt.init_step   = cln_pkg::INIT_NONE;
								nxt.shifts_left = cur.shifts_left - 9'd1;
							end else begin
								nxt.init_step = cln_pkg::INIT_NONE;
								nxt.phase     = cln_pkg::PH_IDLE;
								nxt.hold_left = 2'd0;
							end
						end
					endcase
				end
			end
		end else if (cur.phase == cln_pkg::PH_IDLE) begin
			accepted = 1'b1;
			unique case (mode)
				cln_pkg::MODE_INIT: begin
					nxt.init_step    = cln_pkg::INIT_NIBBLE;
					nxt.shifts_left  = 9'd0;
					nxt.cur_byte     = 8'(cln_pkg::INIT_NIB);
					nxt.select_level = 1'b0;
					nxt.enable_level = 1'b0;
					nxt.nibble_level = cln_pkg::INIT_NIB;
					nxt.hold_left    = 2'd0;
					nxt.phase        = cln_pkg::PH_INIT_SET;
				end
				cln_pkg::MODE_CHAR:    nxt = cln_pkg::start_byte(cur, char_code, 1'b1);
				cln_pkg::MODE_CLEAR:   nxt = cln_pkg::start_byte(cur, cln_pkg::CMD_CLEAR, 1'b0);
				cln_pkg::MODE_HOME:    nxt = cln_pkg::start_byte(cur, cln_pkg::CMD_HOME, 1'b0);
				cln_pkg::MODE_DISPLAY: begin
					nxt = cln_pkg::start_byte(cur, cln_pkg::disp_byte(display_select), 1'b0);
				end
				cln_pkg::MODE_CURSOR: begin
					if (row_ok) begin
						nxt = cln_pkg::start_byte(cur,
							cursor_row[0] ? cln_pkg::CMD_LINE1 : cln_pkg::CMD_LINE0, 1'b0);
						nxt.shifts_left = shift_count;
					end else begin
						accepted = 1'b0;
					end
				end
				default: accepted = 1'b0;
			endcase
		end
	end

endmodule
